### rtl/ehas_pkg.sv
// ----------------------------------------------------------------------------
// ehas_pkg
// Shared widths, constants, register codes and structs of the echo head
// alignment scan unit.
// ----------------------------------------------------------------------------
package ehas_pkg;

   // field widths
   localparam int DIST_W    = 14;
   localparam int ANGLE_W   = 8;
   localparam int SPAN_W    = 7;
   localparam int STEP_W    = 8;

   // pulse width to millimetres: (width * 10859) >> 16, i.e. 0.1657 mm/us
   localparam int ECHO_SCALE = 10859;
   localparam int SCALE_W    = 14;
   localparam int PROD_W     = DIST_W + SCALE_W;
   localparam int PROD_SHIFT = 16;

   localparam int ANGLE_LIMIT = 90;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_ECHO   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN      = 2'd2;

   // reset values
   localparam logic [DIST_W-1:0] NO_ECHO_RESET   = DIST_W'(10000);
   localparam logic [DIST_W-1:0] VARIATION_RESET = DIST_W'(50);
   localparam logic [SPAN_W-1:0] SPAN_RESET      = SPAN_W'(10);

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic [DIST_W-1:0] silence_mm;
      logic [DIST_W-1:0] monitor_variation;
      logic [SPAN_W-1:0] saccade_span;
   } ehas_cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0]         distance_mm;
      logic signed [ANGLE_W-1:0] steer_angle;
      logic [DIST_W-1:0]         aligned_distance;
      logic                      aligning;
      logic                      alignment_done;
      logic                      alignment_started;
      logic                      long_wait;
   } ehas_result_type;

endpackage

### rtl/ehas_conv.sv
// ----------------------------------------------------------------------------
// ehas_conv
// Input stage: scale the echo pulse width to millimetres and hold it.
// ----------------------------------------------------------------------------
module ehas_conv
   import ehas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DIST_W-1:0] pulse_width_us,
   input  logic [DIST_W-1:0] silence_mm,
   input  logic              take,
   output logic              dist_valid,
   output logic [DIST_W-1:0] range_mm
);

   logic [PROD_W-1:0]            product;
   logic [PROD_W-PROD_SHIFT-1:0] scaled;
   logic [DIST_W-1:0]            dist_in;
   logic [DIST_W-1:0]            dist_ff;
   logic                         valid_in;
   logic                         valid_ff;

   assign product = pulse_width_us * SCALE_W'(ECHO_SCALE);
   assign scaled  = product[PROD_W-1:PROD_SHIFT];
   // a zero result (timeout or a very short pulse) stands for no echo
   assign dist_in = (scaled == '0) ? silence_mm : DIST_W'(scaled);

   assign in_ready = !valid_ff || take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         dist_ff <= dist_in;
      end
   end

   assign dist_valid = valid_ff;
   assign range_mm   = dist_ff;

endmodule

### rtl/ehas_core.sv
// ----------------------------------------------------------------------------
// ehas_core
// Scan state: distance history, head angle, span and alignment mode.
// ----------------------------------------------------------------------------
module ehas_core
   import ehas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ehas_cfg_type      cfg,
   input  logic              step,
   input  logic [DIST_W-1:0] range_mm,
   output ehas_result_type   result
);

   localparam logic signed [ANGLE_W+1:0] SUM_HI = (ANGLE_W+2)'(ANGLE_LIMIT);
   localparam logic signed [ANGLE_W+1:0] SUM_LO = -SUM_HI;
   localparam logic signed [ANGLE_W-1:0] ANG_HI = ANGLE_W'(ANGLE_LIMIT);
   localparam logic signed [ANGLE_W-1:0] ANG_LO = -ANG_HI;

   function automatic logic signed [ANGLE_W-1:0] clamp_angle(
      input logic signed [ANGLE_W-1:0] a,
      input logic signed [ANGLE_W-1:0] s
   );
      logic signed [ANGLE_W+1:0] sum;
      sum = (ANGLE_W+2)'(a) + (ANGLE_W+2)'(s);
      if (sum < SUM_LO) begin
         return ANG_LO;
      end else if (sum > SUM_HI) begin
         return ANG_HI;
      end
      return ANGLE_W'(sum);
   endfunction

   function automatic logic [DIST_W-1:0] abs_diff(
      input logic [DIST_W-1:0] a,
      input logic [DIST_W-1:0] b
   );
      return (a > b) ? a - b : b - a;
   endfunction

   logic [DIST_W-1:0]         cur_ff,   cur_in;
   logic [DIST_W-1:0]         prev_ff,  prev_in;
   logic [DIST_W-1:0]         min_ff,   min_in;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [ANGLE_W-1:0] span_ff,  span_in;
   logic [STEP_W-1:0]         count_ff, count_in;
   logic                      align_ff, align_in;

   logic                      all_none;
   logic                      at_limit;
   logic signed [ANGLE_W-1:0] span_pos;
   logic signed [ANGLE_W-1:0] span_rev;
   logic                      done;
   logic                      started;

   assign span_pos = ANGLE_W'(cfg.saccade_span);
   assign span_rev = -span_ff;
   assign at_limit = (angle_ff <= ANG_LO) || (angle_ff >= ANG_HI);
   // after the shift: older = prev_ff, previous = cur_ff, current = range_mm
   assign all_none = (cur_ff == cfg.silence_mm) && (range_mm == cfg.silence_mm) &&
                     (prev_ff == cfg.silence_mm);

   always_comb begin
      prev_in  = cur_ff;
      cur_in   = range_mm;
      min_in   = min_ff;
      angle_in = angle_ff;
      span_in  = span_ff;
      count_in = count_ff;
      align_in = align_ff;
      done     = 1'b0;
      started  = 1'b0;
      if (align_ff) begin
         if (count_ff != STEP_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if ((cur_ff > range_mm) || all_none) begin
            if (at_limit) begin
               if (count_in > STEP_W'(1)) begin
                  min_in   = range_mm;
                  align_in = 1'b0;
                  done     = 1'b1;
               end else begin
                  // first step at a limit: step back toward the centre
                  span_in  = (angle_ff >= ANG_HI) ? -span_pos : span_pos;
                  angle_in = clamp_angle(angle_ff, span_in);
               end
            end else begin
               angle_in = clamp_angle(angle_ff, span_ff);
            end
         end else begin
            // echo grew: reverse, and stop if a minimum is bracketed
            span_in  = span_rev;
            angle_in = clamp_angle(angle_ff, span_rev);
            if ((prev_ff >= cur_ff) && (count_in > STEP_W'(2)) &&
                (cur_ff < cfg.silence_mm)) begin
               min_in   = cur_ff;
               align_in = 1'b0;
               done     = 1'b1;
            end
         end
      end else begin
         if ((abs_diff(range_mm, min_ff) > cfg.monitor_variation) &&
             (abs_diff(cur_ff, min_ff) > cfg.monitor_variation)) begin
            align_in = 1'b1;
            cur_in   = cfg.silence_mm - 1'b1;
            span_in  = span_rev;
            count_in = '0;
            started  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= NO_ECHO_RESET;
         prev_ff  <= NO_ECHO_RESET;
         min_ff   <= '0;
         angle_ff <= '0;
         span_ff  <= ANGLE_W'(SPAN_RESET);
         count_ff <= '0;
         align_ff <= 1'b0;
      end else if (step) begin
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
         min_ff   <= min_in;
         angle_ff <= angle_in;
         span_ff  <= span_in;
         count_ff <= count_in;
         align_ff <= align_in;
      end
   end

   always_comb begin
      result.distance_mm       = range_mm;
      result.steer_angle       = angle_in;
      result.aligned_distance  = min_in;
      result.aligning          = align_in;
      result.alignment_done    = done;
      result.alignment_started = started;
      result.long_wait         = !align_in;
   end

endmodule

### rtl/echo_head_alignment_scan_unit.sv
// ----------------------------------------------------------------------------
// echo_head_alignment_scan_unit
// Converts echo pulse widths to distances and steers a head alignment scan.
// ----------------------------------------------------------------------------
// Use:
//   req_*  : one request per echo measurement, tdata[13:0] = pulse width (us).
//   rsp_*  : one result per request, in order: distance, new head angle,
//            aligned minimum and the alignment status flags.
//   csr_*  : register writes (index, data), always ready; write only while
//            no request is in flight.
// Path: the pulse width is scaled by one 14x14 multiplier ahead of the input
//   register; the scan decision runs from the input register and loads the
//   result register.
// Throughput: one request per cycle while rsp_tready is high; the scan state
//   closes its loop within that cycle, so requests may follow back to back.
// Stall: while rsp_tready is low the result register holds; the input stage
//   takes one further request if it is empty, then req_tready drops.
// Reset: empties both stages, loads the register reset values, sets the
//   distance history to 10000, angle to straight ahead and monitoring mode.
// ----------------------------------------------------------------------------
module echo_head_alignment_scan_unit
   import ehas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request: [13:0] pulse_width_us, [15:14] zero
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // result: [13:0] distance_mm, [21:14] steer_angle, [35:22] aligned_distance,
   //         [36] aligning, [37] alignment_done, [38] alignment_started,
   //         [39] long_wait
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DIST_W-1:0]      csr_data
);

   ehas_cfg_type    cfg_ff;
   ehas_result_type result;
   ehas_result_type rsp_ff;
   logic            rsp_valid_ff;
   logic            step;
   logic            dist_valid;
   logic [DIST_W-1:0] range_mm;

   // registers: always take a write; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.silence_mm        <= NO_ECHO_RESET;
         cfg_ff.monitor_variation <= VARIATION_RESET;
         cfg_ff.saccade_span      <= SPAN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NO_ECHO:   cfg_ff.silence_mm        <= csr_data;
            CSR_VARIATION: cfg_ff.monitor_variation <= csr_data;
            CSR_SPAN:      cfg_ff.saccade_span      <= csr_data[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   ehas_conv u_conv (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .pulse_width_us (req_tdata[DIST_W-1:0]),
      .silence_mm     (cfg_ff.silence_mm),
      .take           (step),
      .dist_valid     (dist_valid),
      .range_mm       (range_mm)
   );

   // advance the scan when the result register is free or being emptied
   assign step = dist_valid && (!rsp_valid_ff || rsp_tready);

   ehas_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .step     (step),
      .range_mm (range_mm),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.long_wait, rsp_ff.alignment_started, rsp_ff.alignment_done,
                        rsp_ff.aligning, rsp_ff.aligned_distance, rsp_ff.steer_angle,
                        rsp_ff.distance_mm};

endmodule

### rtl/ehas_checker.sv
// ----------------------------------------------------------------------------
// ehas_checker
// Port-level checks of the echo head alignment scan unit, bound to the top.
// ----------------------------------------------------------------------------
module ehas_checker
   import ehas_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic signed [ANGLE_W-1:0] angle;
   assign angle = rsp_tdata[21:14];

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // long wait exactly when not aligning
   a_wait_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39] != rsp_tdata[36]))
      else $error("long_wait disagrees with aligning");

   // a start leaves alignment running and cannot also end it
   a_start_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38] |-> rsp_tdata[36] && !rsp_tdata[37])
      else $error("alignment start inconsistent");

   // head angle stays within the limits
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (angle >= -ANGLE_W'(ANGLE_LIMIT)) && (angle <= ANGLE_W'(ANGLE_LIMIT)))
      else $error("head angle out of range");

endmodule

bind echo_head_alignment_scan_unit ehas_checker u_ehas_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
